FILE: design/three_channel_windowed_rms_assert.svh
// Assertion macros for the three-channel windowed RMS block.
`ifndef THREE_CHANNEL_WINDOWED_RMS_ASSERT_SVH
`define THREE_CHANNEL_WINDOWED_RMS_ASSERT_SVH
`ifndef SYNTHESIS
`define TCWR_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`define TCWR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define TCWR_ASSERT(label, cond)
`define TCWR_ASSERT_IMPL(label, ante, cons)
`endif
`endif

FILE: design/tcwr_pkg.sv
// Shared types and constants of the three-channel windowed RMS block.
package tcwr_pkg;
  localparam int Window = 400;
  localparam int NumLanes = 3;
  localparam int CntW = 9;
  localparam int RootBits = 28;
  typedef enum logic [2:0] {
    REG_VGAIN = 3'd0, REG_IGAIN = 3'd1, REG_TGAIN = 3'd2,
    REG_VOFF = 3'd3, REG_DROOP = 3'd4, REG_IREF = 3'd5
  } reg_idx_t;
  localparam logic [31:0] VGainRst = 32'd36974085;
  localparam logic [31:0] IGainRst = 32'd1327024;
  localparam logic [31:0] TGainRst = 32'd3311291;
  localparam logic [30:0] VOffRst = 31'd3277;
  localparam logic [30:0] DroopRst = 31'd13666;
  localparam logic [30:0] IRefRst = 31'd98304;
  typedef struct packed {
    logic start;
    logic clear;
  } lane_ctl_t;
endpackage

FILE: design/tcwr_lane.sv
// One channel lane: gain scaling, saturating square sum and windowed square root.
module tcwr_lane (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tcwr_pkg::lane_ctl_t  ctl,
  input  logic signed [15:0]   code,
  input  logic [31:0]          gain,
  input  logic                 sample_en,
  output logic signed [31:0]   now_val,
  output logic [30:0]          rms,
  output logic                 busy
);
  import tcwr_pkg::*;
  `include "three_channel_windowed_rms_assert.svh"

  typedef enum logic [2:0] {S_IDLE, S_SQ, S_ACC, S_DIV, S_SQRT} st_t;

  st_t st_r;
  logic signed [48:0] prod_r;
  logic signed [31:0] now_r;
  logic [63:0] sq_r, acc_r, x_r;
  logic [RootBits-1:0] res_r;
  logic [67:0] p_r, f_r, e_r;
  logic [4:0]  step_r;
  logic        pend_r;

  logic signed [48:0] prod_c;
  logic signed [32:0] shf_c;
  logic signed [31:0] sat_c;
  logic [31:0] mag_c;
  logic [64:0] sum_c;
  logic [63:0] acc_c;
  logic [67:0] cand_c;
  logic        fit_c;

  assign prod_c = 49'(code) * $signed({17'd0, gain});
  assign shf_c = 33'(prod_r >>> 16);
  assign sat_c = (shf_c > 33'sd2147483647) ? 32'h7fffffff :
                 (shf_c < -33'sd2147483648) ? 32'h80000000 : shf_c[31:0];
  assign mag_c = now_r[31] ? 32'(-now_r) : now_r;
  assign sum_c = {1'b0, acc_r} + {1'b0, sq_r};
  assign acc_c = sum_c[64] ? '1 : sum_c[63:0];
  // The root is the largest value whose square times the window fits under the sum.
  assign cand_c = p_r + f_r + e_r;
  assign fit_c = (cand_c <= {4'd0, x_r});

  always_ff @(posedge clk) begin
    prod_r <= prod_c;
    if (!rst_n) begin
      st_r <= S_IDLE; acc_r <= '0; now_r <= '0; rms <= '0; pend_r <= 1'b0;
      step_r <= '0;
    end else begin
      unique case (st_r)
        S_IDLE: begin
          if (sample_en) begin
            st_r <= S_SQ; pend_r <= ctl.start;
          end
        end
        S_SQ: begin
          now_r <= sat_c; st_r <= S_ACC;
        end
        S_ACC: begin
          sq_r <= 64'(mag_c) * 64'(mag_c);
          st_r <= S_DIV;
        end
        S_DIV: begin
          acc_r <= pend_r ? '0 : acc_c;
          if (!pend_r) st_r <= S_IDLE;
          else begin
            x_r <= acc_c; p_r <= '0; f_r <= '0; res_r <= '0;
            e_r <= 68'(Window) << (2 * (RootBits - 1));
            step_r <= 5'(RootBits - 1); st_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (fit_c) begin
            p_r <= cand_c; f_r <= (f_r + {e_r[66:0], 1'b0}) >> 1;
          end else f_r <= f_r >> 1;
          e_r <= e_r >> 2;
          res_r <= {res_r[RootBits-2:0], fit_c};
          if (step_r == '0) begin
            rms <= 31'({res_r[RootBits-2:0], fit_c});
            st_r <= S_IDLE;
          end else step_r <= step_r - 5'd1;
        end
        default: st_r <= S_IDLE;
      endcase
      if (ctl.clear) acc_r <= '0;
    end
  end

  assign now_val = now_r;
  assign busy = (st_r != S_IDLE);

  `TCWR_ASSERT_IMPL(a_idle_start, sample_en, st_r == S_IDLE)
  `TCWR_ASSERT_IMPL(a_sqrt_pend, st_r == S_SQRT, pend_r)
  `TCWR_ASSERT(a_step_rng, st_r != S_SQRT || step_r <= 5'(RootBits - 1))
endmodule

FILE: design/tcwr_merge.sv
// Merge stage: droop and offset correction of the voltage RMS.
module tcwr_merge (
  input  logic               clk,
  input  logic               go,
  input  logic [30:0]        vr,
  input  logic [30:0]        ir,
  input  logic [30:0]        voff,
  input  logic [30:0]        droop,
  input  logic [30:0]        iref,
  output logic signed [31:0] vcorr
);
  import tcwr_pkg::*;
  logic signed [63:0] prod_r;
  logic signed [48:0] corr_c;
  logic signed [47:0] dr_c;
  logic signed [31:0] diff_c;

  assign diff_c = $signed({1'b0, ir}) - $signed({1'b0, iref});
  assign dr_c = 48'(prod_r >>> 16);
  assign corr_c = $signed({18'd0, vr}) - $signed({18'd0, voff}) - 49'(dr_c);

  always_ff @(posedge clk) begin
    prod_r <= 64'($signed({1'b0, droop})) * 64'(diff_c);
    if (go) begin
      vcorr <= (corr_c > 49'sd2147483647) ? 32'h7fffffff :
               (corr_c < -49'sd2147483648) ? 32'h80000000 : corr_c[31:0];
    end
  end
endmodule

FILE: design/three_channel_windowed_rms.sv
// Top level of the three-channel windowed RMS block.
// The block takes no new sample until the previous transaction's result has left the output
// register. A transaction that closes a window of 400 samples runs the 28-step square root
// in each of the three parallel channel lanes, which tests the window length times the
// squared candidate against the sum, followed by droop correction in the merge stage.
// Results wait in an output register while the result channel stalls.
module three_channel_windowed_rms (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_voltage_code,
  input  logic signed [15:0] in_current_code,
  input  logic signed [15:0] in_total_current_code,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_voltage_now,
  output logic signed [31:0] out_current_now,
  output logic signed [31:0] out_total_current_now,
  output logic               out_rms_valid,
  output logic signed [31:0] out_voltage_rms,
  output logic [30:0]        out_current_rms,
  output logic [30:0]        out_total_current_rms,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import tcwr_pkg::*;
  `include "three_channel_windowed_rms_assert.svh"

  typedef enum logic [1:0] {T_IDLE, T_RUN, T_MRG, T_OUT} st_t;

  st_t st_r;
  logic [31:0] vg_r, ig_r, tg_r;
  logic [30:0] voff_r, droop_r, iref_r;
  logic [CntW-1:0] cnt_r;
  logic done_r;
  logic [1:0] wait_r;
  logic signed [15:0] code [NumLanes];
  logic [31:0] gains [NumLanes];
  logic signed [31:0] nowv [NumLanes];
  logic [30:0] rmsv [NumLanes];
  logic [NumLanes-1:0] busy;
  logic signed [31:0] vcorr;
  lane_ctl_t ctl;
  logic acc;
  logic [CntW-1:0] cnt_inc;

  assign acc = in_valid && !in_stall;
  assign in_stall = (st_r != T_IDLE);
  assign cnt_inc = cnt_r + 1'b1;
  assign ctl.start = (cnt_inc >= CntW'(Window)) || (cnt_inc == '0);
  assign ctl.clear = 1'b0;
  assign code[0] = in_voltage_code;
  assign code[1] = in_current_code;
  assign code[2] = in_total_current_code;
  assign gains[0] = vg_r;
  assign gains[1] = ig_r;
  assign gains[2] = tg_r;

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    tcwr_lane u_lane (
      .clk, .rst_n, .ctl, .code(code[g]), .gain(gains[g]), .sample_en(acc),
      .now_val(nowv[g]), .rms(rmsv[g]), .busy(busy[g])
    );
  end

  tcwr_merge u_merge (
    .clk, .go(st_r == T_MRG && wait_r == 2'd2), .vr(rmsv[0]), .ir(rmsv[1]),
    .voff(voff_r), .droop(droop_r), .iref(iref_r), .vcorr
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= T_IDLE; out_valid <= 1'b0; cnt_r <= '0; done_r <= 1'b0; wait_r <= '0;
      vg_r <= VGainRst; ig_r <= IGainRst; tg_r <= TGainRst;
      voff_r <= VOffRst; droop_r <= DroopRst; iref_r <= IRefRst;
      out_voltage_rms <= '0; out_current_rms <= '0; out_total_current_rms <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_VGAIN: vg_r <= cfg_data;
          REG_IGAIN: ig_r <= cfg_data;
          REG_TGAIN: tg_r <= cfg_data;
          REG_VOFF:  voff_r <= cfg_data[30:0];
          REG_DROOP: droop_r <= cfg_data[30:0];
          REG_IREF:  iref_r <= cfg_data[30:0];
          default: ;
        endcase
      end
      unique case (st_r)
        T_IDLE: begin
          if (acc) begin
            st_r <= T_RUN; done_r <= ctl.start;
            cnt_r <= ctl.start ? '0 : cnt_inc;
          end
        end
        T_RUN: begin
          if (busy == '0) begin
            st_r <= done_r ? T_MRG : T_OUT; wait_r <= '0;
          end
        end
        T_MRG: begin
          wait_r <= wait_r + 2'd1;
          if (wait_r == 2'd3) begin
            out_voltage_rms <= vcorr; out_current_rms <= rmsv[1];
            out_total_current_rms <= rmsv[2]; st_r <= T_OUT;
          end
        end
        T_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1; out_rms_valid <= done_r;
            out_voltage_now <= nowv[0]; out_current_now <= nowv[1];
            out_total_current_now <= nowv[2];
          end else if (!out_stall) begin
            out_valid <= 1'b0; st_r <= T_IDLE;
          end
        end
        default: st_r <= T_IDLE;
      endcase
    end
  end

  `TCWR_ASSERT_IMPL(a_out_only_done, out_valid, st_r == T_OUT)
  `TCWR_ASSERT_IMPL(a_lanes_sync, st_r == T_IDLE, busy == '0)
  `TCWR_ASSERT(a_cnt_rng, cnt_r < CntW'(Window))
endmodule
